/* src/tcpqs_pkg.sv */
`default_nettype none

package tcpqs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned EVT_W  = 32;
  localparam int unsigned SUM_W  = 48;

  // Opcodes; any other code is a service tick.
  localparam logic [OP_W-1:0] OP_HIGH_REQ = 2'd0;
  localparam logic [OP_W-1:0] OP_LOW_REQ  = 2'd1;

  localparam logic [CODE_W-1:0] RES_ACCEPTED    = 3'd0;
  localparam logic [CODE_W-1:0] RES_REFUSED     = 3'd1;
  localparam logic [CODE_W-1:0] RES_SERVED_HIGH = 3'd2;
  localparam logic [CODE_W-1:0] RES_SERVED_LOW  = 3'd3;
  localparam logic [CODE_W-1:0] RES_IDLE        = 3'd4;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [EVT_W-1:0] EVT_MAX     = '1;
  localparam logic [SUM_W-1:0] SUM_MAX     = '1;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] time_value;
    logic [TAG_W-1:0]  entry_tag;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic [TAG_W-1:0]  served_tag;
    logic [TIME_W-1:0] served_wait;
    logic [CNT_W-1:0]  high_queue_count;
    logic [CNT_W-1:0]  low_queue_count;
    logic [EVT_W-1:0]  high_accepted;
    logic [EVT_W-1:0]  high_refused;
    logic [EVT_W-1:0]  low_accepted;
    logic [EVT_W-1:0]  low_refused;
    logic [EVT_W-1:0]  idle_ticks;
    logic [SUM_W-1:0]  high_wait_total;
    logic [SUM_W-1:0]  low_wait_total;
  } res_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    entry_t           head;
  } q_stat_t;

  typedef struct packed {
    logic              high_acc;
    logic              high_ref;
    logic              low_acc;
    logic              low_ref;
    logic              idle;
    logic              high_served;
    logic              low_served;
    logic [TIME_W-1:0] served_wait;
  } stats_evt_t;

  typedef struct packed {
    logic [EVT_W-1:0] high_accepted;
    logic [EVT_W-1:0] high_refused;
    logic [EVT_W-1:0] low_accepted;
    logic [EVT_W-1:0] low_refused;
    logic [EVT_W-1:0] idle_ticks;
    logic [SUM_W-1:0] high_wait_total;
    logic [SUM_W-1:0] low_wait_total;
  } stats_t;

endpackage

`default_nettype wire

/* src/tcpqs_queue.sv */
`default_nettype none

module tcpqs_queue #(
  parameter int unsigned DEPTH = tcpqs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcpqs_pkg::q_ctl_t  ctl,
  input  wire tcpqs_pkg::entry_t  entry_in,
  output tcpqs_pkg::q_stat_t      stat
);
  import tcpqs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ADD_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam logic [ADD_W-1:0] DEPTH_A = ADD_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);

  entry_t mem [DEPTH];

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] head_plus;
  logic [PTR_W-1:0] rd_addr;
  logic [PTR_W-1:0] wr_addr;
  logic [ADD_W-1:0] wr_sum;
  logic [CNT_W-1:0] count;
  entry_t           hd;
  entry_t           pf;

  always_comb begin
    wr_sum    = ADD_W'(head) + ADD_W'(count);
    wr_addr   = (wr_sum >= DEPTH_A) ? PTR_W'(wr_sum - DEPTH_A) : wr_sum[PTR_W-1:0];
    head_plus = (head == LAST) ? '0 : head + 1'b1;
    head_next = ctl.pop ? head_plus : head;
    rd_addr   = (head_next == LAST) ? '0 : head_next + 1'b1;
  end

  // The entry behind the head is prefetched every cycle, so that a pop can
  // hand it straight to the head register. A write into that very slot is
  // forwarded, which happens when the second entry goes in.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= entry_in;
    end
    if (ctl.push && (wr_addr == rd_addr)) begin
      pf <= entry_in;
    end else begin
      pf <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && (count == '0)) begin
      hd <= entry_in;
    end else if (ctl.pop) begin
      hd <= pf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctl.push) begin
        count <= count + 1'b1;
      end else if (ctl.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign stat.count = count;
  assign stat.head  = hd;

`ifndef NO_ASSERTIONS
  a_no_push_pop : assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("queue pushed and popped by one item");

  a_count_depth : assert property (@(posedge clk) disable iff (rst)
    (ADD_W'(count) <= DEPTH_A))
    else $error("queue count exceeds depth");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (count != '0))
    else $error("pop from an empty queue");

  a_first_head : assert property (@(posedge clk) disable iff (rst)
    (ctl.push && (count == '0)) |=> (hd == $past(entry_in)))
    else $error("head entry not loaded on first push");
`endif

endmodule

`default_nettype wire

/* src/tcpqs_stats.sv */
`default_nettype none

module tcpqs_stats (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tcpqs_pkg::stats_evt_t  evt,
  output tcpqs_pkg::stats_t           stats
);
  import tcpqs_pkg::*;

  logic [EVT_W-1:0] high_acc;
  logic [EVT_W-1:0] high_ref;
  logic [EVT_W-1:0] low_acc;
  logic [EVT_W-1:0] low_ref;
  logic [EVT_W-1:0] idle_cnt;
  logic [SUM_W-1:0] high_sum;
  logic [SUM_W-1:0] low_sum;
  logic [SUM_W-1:0] served_sum;
  logic [SUM_W:0]   add_full;
  logic [SUM_W-1:0] sum_next;

  function automatic logic [EVT_W-1:0] bump(input logic [EVT_W-1:0] c);
    bump = (c == EVT_MAX) ? c : c + 1'b1;
  endfunction

  // Only one class is served per item, so one adder serves both sums.
  always_comb begin
    served_sum = evt.high_served ? high_sum : low_sum;
    add_full   = {1'b0, served_sum} + (SUM_W + 1)'(evt.served_wait);
    sum_next   = (add_full >= {1'b0, SUM_MAX}) ? SUM_MAX : add_full[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_acc <= '0;
      high_ref <= '0;
      low_acc  <= '0;
      low_ref  <= '0;
      idle_cnt <= '0;
      high_sum <= '0;
      low_sum  <= '0;
    end else begin
      if (evt.high_acc) begin
        high_acc <= bump(high_acc);
      end
      if (evt.high_ref) begin
        high_ref <= bump(high_ref);
      end
      if (evt.low_acc) begin
        low_acc <= bump(low_acc);
      end
      if (evt.low_ref) begin
        low_ref <= bump(low_ref);
      end
      if (evt.idle) begin
        idle_cnt <= bump(idle_cnt);
      end
      if (evt.high_served) begin
        high_sum <= sum_next;
      end
      if (evt.low_served) begin
        low_sum <= sum_next;
      end
    end
  end

  assign stats.high_accepted   = high_acc;
  assign stats.high_refused    = high_ref;
  assign stats.low_accepted    = low_acc;
  assign stats.low_refused     = low_ref;
  assign stats.idle_ticks      = idle_cnt;
  assign stats.high_wait_total = high_sum;
  assign stats.low_wait_total  = low_sum;

`ifndef NO_ASSERTIONS
  a_idle_sat : assert property (@(posedge clk) disable iff (rst)
    (idle_cnt == EVT_MAX) |=> (idle_cnt == EVT_MAX))
    else $error("idle counter left saturation");

  a_high_sum_mono : assert property (@(posedge clk) disable iff (rst)
    evt.high_served |=> (high_sum >= $past(high_sum)))
    else $error("high wait sum decreased");

  a_low_sum_sat : assert property (@(posedge clk) disable iff (rst)
    (low_sum == SUM_MAX) |=> (low_sum == SUM_MAX))
    else $error("low wait sum left saturation");

  a_one_event : assert property (@(posedge clk) disable iff (rst)
    $onehot0({evt.high_acc, evt.high_ref, evt.low_acc, evt.low_ref, evt.idle,
              evt.high_served, evt.low_served}))
    else $error("more than one statistics event per item");
`endif

endmodule

`default_nettype wire

/* src/two_class_priority_queue_scheduler.sv */
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   tcpqs_pkg::req_t
// res       out        res_valid / res_stall   tcpqs_pkg::res_t
// cfg       in         cfg_wr_en               cfg_wr_data (queue limit)
//
// One item is taken per cycle unless res stalls; it waits in the input register and
// its result is written to the result register when it fires.
// Each item does at most one queue push or pop; queue heads are held in registers
// and the entry behind each head is prefetched from its memory.
// Reset clears the queue pointers, counts and statistics; queue memories need none.
// A stall on res holds the result and, once the input register is full, stalls req.
`default_nettype none

module two_class_priority_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = tcpqs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire tcpqs_pkg::req_t            req,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output tcpqs_pkg::res_t                 res,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tcpqs_pkg::CNT_W-1:0] cfg_wr_data
);
  import tcpqs_pkg::*;

  localparam bit               CAPPED    = (QUEUE_DEPTH < 32);
  localparam logic [CNT_W-1:0] DEPTH_CAP = CAPPED ? CNT_W'(QUEUE_DEPTH) : '1;

  req_t             in_reg;
  logic             in_full;
  logic             out_full;
  logic             fire;
  logic [CNT_W-1:0] admit_limit;
  logic [CNT_W-1:0] limit_eff;

  logic              is_hreq;
  logic              is_lreq;
  logic              is_tick;
  logic              high_ok;
  logic              low_ok;
  logic              pop_high;
  logic              pop_low;
  entry_t            served;
  logic [TIME_W-1:0] wait_val;

  logic [CODE_W-1:0] code_next;
  logic [CODE_W-1:0] code_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] wait_r;

  q_ctl_t     hctl;
  q_ctl_t     lctl;
  q_stat_t    hstat;
  q_stat_t    lstat;
  entry_t     new_entry;
  stats_evt_t evt;
  stats_t     stats;

  assign fire      = in_full && (!out_full || !res_stall);
  assign req_stall = in_full && !fire;
  assign res_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      out_full    <= 1'b0;
      admit_limit <= LIMIT_RESET;
    end else begin
      if (req_valid && !req_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        out_full <= 1'b1;
      end else if (!res_stall) begin
        out_full <= 1'b0;
      end
      if (cfg_wr_en) begin
        admit_limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_reg <= req;
    end
  end

  always_comb begin
    limit_eff = (admit_limit > DEPTH_CAP) ? DEPTH_CAP : admit_limit;
    is_hreq   = (in_reg.opcode == OP_HIGH_REQ);
    is_lreq   = (in_reg.opcode == OP_LOW_REQ);
    is_tick   = !is_hreq && !is_lreq;
    high_ok   = (hstat.count < limit_eff);
    low_ok    = (lstat.count < limit_eff);
    pop_high  = is_tick && (hstat.count != '0);
    pop_low   = is_tick && (hstat.count == '0) && (lstat.count != '0);
    served    = pop_high ? hstat.head : lstat.head;
    wait_val  = in_reg.time_value - served.stamp;

    if (is_hreq) begin
      code_next = high_ok ? RES_ACCEPTED : RES_REFUSED;
    end else if (is_lreq) begin
      code_next = low_ok ? RES_ACCEPTED : RES_REFUSED;
    end else if (pop_high) begin
      code_next = RES_SERVED_HIGH;
    end else if (pop_low) begin
      code_next = RES_SERVED_LOW;
    end else begin
      code_next = RES_IDLE;
    end
  end

  assign new_entry.tag   = in_reg.entry_tag;
  assign new_entry.stamp = in_reg.time_value;

  assign hctl.push = fire && is_hreq && high_ok;
  assign hctl.pop  = fire && pop_high;
  assign lctl.push = fire && is_lreq && low_ok;
  assign lctl.pop  = fire && pop_low;

  assign evt.high_acc    = fire && is_hreq && high_ok;
  assign evt.high_ref    = fire && is_hreq && !high_ok;
  assign evt.low_acc     = fire && is_lreq && low_ok;
  assign evt.low_ref     = fire && is_lreq && !low_ok;
  assign evt.idle        = fire && is_tick && !pop_high && !pop_low;
  assign evt.high_served = fire && pop_high;
  assign evt.low_served  = fire && pop_low;
  assign evt.served_wait = wait_val;

  tcpqs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_high_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (hctl),
    .entry_in (new_entry),
    .stat     (hstat)
  );

  tcpqs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_low_queue (
    .clk      (clk),
    .rst      (rst),
    .ctl      (lctl),
    .entry_in (new_entry),
    .stat     (lstat)
  );

  tcpqs_stats u_stats (
    .clk   (clk),
    .rst   (rst),
    .evt   (evt),
    .stats (stats)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      code_r <= code_next;
      tag_r  <= (pop_high || pop_low) ? served.tag : '0;
      wait_r <= (pop_high || pop_low) ? wait_val : '0;
    end
  end

  // Queue state and statistics change only when an item fires, which also
  // replaces the result, so they can be shown straight from their registers.
  assign res.result_code      = code_r;
  assign res.served_tag       = tag_r;
  assign res.served_wait      = wait_r;
  assign res.high_queue_count = hstat.count;
  assign res.low_queue_count  = lstat.count;
  assign res.high_accepted    = stats.high_accepted;
  assign res.high_refused     = stats.high_refused;
  assign res.low_accepted     = stats.low_accepted;
  assign res.low_refused      = stats.low_refused;
  assign res.idle_ticks       = stats.idle_ticks;
  assign res.high_wait_total  = stats.high_wait_total;
  assign res.low_wait_total   = stats.low_wait_total;

`ifndef NO_ASSERTIONS
  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !req_stall)
    else $error("request stalled with an empty input register");

  a_pop_high_count : assert property (@(posedge clk) disable iff (rst)
    hctl.pop |=> (hstat.count == $past(hstat.count) - 1'b1))
    else $error("high count not decremented on service");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.result_code == RES_IDLE)) |->
      ((res.high_queue_count == '0) && (res.low_queue_count == '0)))
    else $error("idle result with a queue not empty");

  a_unserved_zero : assert property (@(posedge clk) disable iff (rst)
    (res_valid && ((res.result_code == RES_ACCEPTED) ||
                   (res.result_code == RES_REFUSED) ||
                   (res.result_code == RES_IDLE))) |->
      ((res.served_tag == '0) && (res.served_wait == '0)))
    else $error("served fields set on an item that served nothing");

  a_low_waits_high : assert property (@(posedge clk) disable iff (rst)
    lctl.pop |-> (hstat.count == '0))
    else $error("low queue served while high queue holds entries");
`endif

endmodule

`default_nettype wire
